FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL in this folder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/ethhdr_pkg.sv
// ---------------------------------------------------------------------------
// ethhdr_pkg
// Types and constants for the Ethernet / IPv4 / TCP header extractor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ethhdr_pkg;

   // Frame layout offsets, in bytes from the start of the frame.
   localparam logic [15:0] MAC_LEN       = 16'd6;
   localparam logic [15:0] ETH_HDR_LEN   = 16'd14;
   localparam logic [15:0] IP_SRC_POS    = 16'd26;
   localparam logic [15:0] IP_ADDR_LEN   = 16'd4;
   localparam logic [15:0] TCP_PORT_LEN  = 16'd2;
   localparam logic [15:0] TCP_DOFF_OFS  = 16'd12;
   localparam logic [15:0] POS_MAX       = 16'hFFFF;

   // Reset value of the IPv4 EtherType register.
   localparam logic [15:0] IPV4_ETHERTYPE_RST = 16'h0800;

   // Default depth of the payload capture.
   localparam int PAYLOAD_BYTES_DEF = 10;

   // Result kinds.
   localparam logic KIND_SUMMARY = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [47:0] dest_mac;
      logic [47:0] source_mac;
      logic        is_ipv4;
      logic [31:0] source_ip;
      logic [31:0] dest_ip;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [7:0]  payload_start;
      logic [7:0]  payload_value;
      logic [15:0] captured_length;
      logic        last_of_frame;
   } rsp_type;

endpackage

FILE: rtl/core/eth_ipv4_tcp_header_extractor.sv
// ---------------------------------------------------------------------------
// eth_ipv4_tcp_header_extractor
// Parses an Ethernet / IPv4 / TCP frame byte by byte and reports a summary
// followed, for IPv4 frames, by the first payload bytes of each frame.
// ---------------------------------------------------------------------------
// Usage:
//   The req channel carries one frame byte per transaction, with frame_end
//   set on the last byte. The csr port writes the IPv4 EtherType; the user
//   must write it only while idle, the block itself does not enforce it.
//   For every frame the rsp channel returns one summary transaction
//   (kind = 0) and then, for IPv4 frames, up to PAYLOAD_BYTES payload
//   transactions (kind = 1). The final transaction of a frame has
//   last_of_frame set. Throughput: one frame byte per cycle unless
//   req_stall and one result per cycle unless rsp_stall. After the last
//   byte of a frame is accepted, the summary passes the head and output
//   registers when no earlier frame is being reported; payload bytes
//   follow one per cycle unless rsp_stall, from a two-bank payload RAM
//   (one bank fills while the other drains). The input stalls only while a
//   second finished frame waits behind the frame being reported; a rsp
//   stall holds the output and, once a frame is queued, backs up into
//   req_stall. Reset clears all frame state and restores the EtherType to
//   0x0800; the payload RAM needs no clearing, since only entries written
//   in the current frame are ever read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module eth_ipv4_tcp_header_extractor #(
   parameter int PAYLOAD_BYTES = ethhdr_pkg::PAYLOAD_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  ethhdr_pkg::req_type req_data,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ethhdr_pkg::rsp_type rsp_data,

   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data
);

   localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);
   localparam int AW    = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam int DEPTH = 2 ** (AW + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(PAYLOAD_BYTES);

   // Configuration register.
   logic [15:0] cfg_etype_ff;

   // Per-frame parse state.
   logic [15:0]      pos_ff,   pos_in;
   logic [47:0]      dmac_ff,  dmac_in;
   logic [47:0]      smac_ff,  smac_in;
   logic [15:0]      etype_ff, etype_in;
   logic [3:0]       ihl_ff,   ihl_in;
   logic [3:0]       doff_ff,  doff_in;
   logic [31:0]      sip_ff,   sip_in;
   logic [31:0]      dip_ff,   dip_in;
   logic [15:0]      sport_ff, sport_in;
   logic [15:0]      dport_ff, dport_in;
   logic [CNT_W-1:0] pcnt_ff,  pcnt_in;
   logic             wbank_ff, wbank_in;

   // Frame queue: the frame being reported (head) and one waiting frame.
   logic                head_valid_ff, head_valid_in;
   ethhdr_pkg::rsp_type head_sum_ff,  head_sum_in;
   logic [CNT_W-1:0]    head_cnt_ff,  head_cnt_in;
   logic                head_bank_ff, head_bank_in;
   logic [CNT_W-1:0]    idx_ff,       idx_in;
   logic                pend_valid_ff, pend_valid_in;
   ethhdr_pkg::rsp_type pend_sum_ff,  pend_sum_in;
   logic [CNT_W-1:0]    pend_cnt_ff,  pend_cnt_in;
   logic                pend_bank_ff, pend_bank_in;

   // Output register; the payload byte comes from the RAM read register.
   logic                rsp_valid_ff, rsp_valid_in;
   ethhdr_pkg::rsp_type rsp_data_ff,  rsp_data_in;
   logic [7:0]          rd_data_ff;

   // Payload RAM, two banks of 2**AW bytes.
   logic [7:0]  pay_mem [DEPTH];
   logic        mem_we;
   logic [AW:0] mem_waddr;
   logic        mem_re;
   logic [AW:0] mem_raddr;

   // Parse datapath.
   logic                req_acc;
   logic                frame_done;
   logic [7:0]          b;
   logic [15:0]         p;
   logic [7:0]          tcp_start;
   logic [15:0]         tcp_pos;
   logic [15:0]         doff_pos;
   logic [7:0]          pay_start;
   logic [15:0]         pay_pos;
   logic                collect;
   logic                is_ipv4;
   logic [CNT_W-1:0]    cnt_eff;
   ethhdr_pkg::rsp_type new_sum;

   // Output engine.
   logic             out_free;
   logic             emit;
   logic             emit_last;
   logic             head_done;
   logic             head_take_new;
   logic [CNT_W-1:0] rd_idx;

   assign req_acc    = req_valid && !req_stall;
   assign frame_done = req_acc && req_data.frame_end;
   assign req_stall  = pend_valid_ff;
   assign b          = req_data.frame_byte;
   assign p          = pos_ff;

   // Configuration write.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_etype_ff <= ethhdr_pkg::IPV4_ETHERTYPE_RST;
      end else if (csr_wr_en) begin
         cfg_etype_ff <= csr_wr_data;
      end
   end

   // Header field capture for the byte at the current position.
   always_comb begin
      dmac_in  = dmac_ff;
      smac_in  = smac_ff;
      etype_in = etype_ff;
      if (p < ethhdr_pkg::MAC_LEN) begin
         dmac_in = {dmac_ff[39:0], b};
      end else if (p < 16'(2 * ethhdr_pkg::MAC_LEN)) begin
         smac_in = {smac_ff[39:0], b};
      end else if (p < ethhdr_pkg::ETH_HDR_LEN) begin
         etype_in = {etype_ff[7:0], b};
      end

      ihl_in = (p == ethhdr_pkg::ETH_HDR_LEN) ? b[3:0] : ihl_ff;

      sip_in = sip_ff;
      dip_in = dip_ff;
      if (p >= ethhdr_pkg::IP_SRC_POS &&
          p < ethhdr_pkg::IP_SRC_POS + ethhdr_pkg::IP_ADDR_LEN) begin
         sip_in = {sip_ff[23:0], b};
      end else if (p >= ethhdr_pkg::IP_SRC_POS + ethhdr_pkg::IP_ADDR_LEN &&
                   p < ethhdr_pkg::IP_SRC_POS + 16'(2 * ethhdr_pkg::IP_ADDR_LEN)) begin
         dip_in = {dip_ff[23:0], b};
      end

      // The TCP header begins right after the IP header.
      tcp_start = 8'(ethhdr_pkg::ETH_HDR_LEN) + {2'b00, ihl_in, 2'b00};
      tcp_pos   = 16'(tcp_start);
      sport_in  = sport_ff;
      dport_in  = dport_ff;
      if (p >= tcp_pos && p < tcp_pos + ethhdr_pkg::TCP_PORT_LEN) begin
         sport_in = {sport_ff[7:0], b};
      end else if (p >= tcp_pos + ethhdr_pkg::TCP_PORT_LEN &&
                   p < tcp_pos + 16'(2 * ethhdr_pkg::TCP_PORT_LEN)) begin
         dport_in = {dport_ff[7:0], b};
      end

      doff_pos = tcp_pos + ethhdr_pkg::TCP_DOFF_OFS;
      doff_in  = (p == doff_pos) ? b[7:4] : doff_ff;

      // Payload bytes are kept once the data offset is known.
      pay_start = tcp_start + {2'b00, doff_in, 2'b00};
      pay_pos   = 16'(pay_start);
      collect   = (p >= doff_pos) && (p >= pay_pos) &&
                  (p < pay_pos + 16'(PAYLOAD_BYTES)) && (pcnt_ff < CNT_MAX);
      pcnt_in   = collect ? pcnt_ff + CNT_W'(1) : pcnt_ff;

      pos_in = (p != ethhdr_pkg::POS_MAX) ? p + 16'd1 : p;
   end

   // Summary of the frame that ends with this byte.
   always_comb begin
      is_ipv4 = (pos_in >= ethhdr_pkg::ETH_HDR_LEN) && (etype_in == cfg_etype_ff);
      cnt_eff = is_ipv4 ? pcnt_in : '0;

      new_sum                 = '0;
      new_sum.kind            = ethhdr_pkg::KIND_SUMMARY;
      new_sum.dest_mac        = dmac_in;
      new_sum.source_mac      = smac_in;
      new_sum.is_ipv4         = is_ipv4;
      new_sum.captured_length = pos_in;
      new_sum.last_of_frame   = (cnt_eff == '0);
      if (is_ipv4) begin
         new_sum.source_ip     = sip_in;
         new_sum.dest_ip       = dip_in;
         new_sum.source_port   = sport_in;
         new_sum.dest_port     = dport_in;
         new_sum.payload_start = pay_start;
      end
   end

   // Parse state registers; a finished frame clears them and flips the bank.
   always_ff @(posedge clock) begin
      if (reset || frame_done) begin
         pos_ff   <= '0;
         dmac_ff  <= '0;
         smac_ff  <= '0;
         etype_ff <= '0;
         ihl_ff   <= '0;
         doff_ff  <= '0;
         sip_ff   <= '0;
         dip_ff   <= '0;
         sport_ff <= '0;
         dport_ff <= '0;
         pcnt_ff  <= '0;
      end else if (req_acc) begin
         pos_ff   <= pos_in;
         dmac_ff  <= dmac_in;
         smac_ff  <= smac_in;
         etype_ff <= etype_in;
         ihl_ff   <= ihl_in;
         doff_ff  <= doff_in;
         sip_ff   <= sip_in;
         dip_ff   <= dip_in;
         sport_ff <= sport_in;
         dport_ff <= dport_in;
         pcnt_ff  <= pcnt_in;
      end
   end

   assign wbank_in = frame_done ? !wbank_ff : wbank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wbank_ff <= 1'b0;
      end else begin
         wbank_ff <= wbank_in;
      end
   end

   // Output engine: index zero is the summary, index k is payload byte k-1.
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign emit          = head_valid_ff && out_free;
   assign emit_last     = (idx_ff == head_cnt_ff);
   assign head_done     = emit && emit_last;
   assign head_take_new = frame_done && (!head_valid_ff || (head_done && !pend_valid_ff));
   assign rd_idx        = idx_ff - CNT_W'(1);

   assign mem_we    = req_acc && collect;
   assign mem_waddr = {wbank_ff, pcnt_ff[AW-1:0]};
   assign mem_re    = emit && (idx_ff != '0);
   assign mem_raddr = {head_bank_ff, rd_idx[AW-1:0]};

   // Frame queue next state.
   always_comb begin
      head_valid_in = head_valid_ff;
      head_sum_in   = head_sum_ff;
      head_cnt_in   = head_cnt_ff;
      head_bank_in  = head_bank_ff;
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_sum_in   = pend_sum_ff;
      pend_cnt_in   = pend_cnt_ff;
      pend_bank_in  = pend_bank_ff;

      priority if (head_take_new) begin
         head_valid_in = 1'b1;
         head_sum_in   = new_sum;
         head_cnt_in   = cnt_eff;
         head_bank_in  = wbank_ff;
         idx_in        = '0;
      end else if (head_done && pend_valid_ff) begin
         head_valid_in = 1'b1;
         head_sum_in   = pend_sum_ff;
         head_cnt_in   = pend_cnt_ff;
         head_bank_in  = pend_bank_ff;
         idx_in        = '0;
      end else if (head_done) begin
         head_valid_in = 1'b0;
         idx_in        = '0;
      end else if (emit) begin
         idx_in = idx_ff + CNT_W'(1);
      end

      // The waiting slot is only filled while it is empty (input stalls otherwise).
      priority if (frame_done && !head_take_new) begin
         pend_valid_in = 1'b1;
         pend_sum_in   = new_sum;
         pend_cnt_in   = cnt_eff;
         pend_bank_in  = wbank_ff;
      end else if (head_done) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
      end
      head_sum_ff  <= head_sum_in;
      head_cnt_ff  <= head_cnt_in;
      head_bank_ff <= head_bank_in;
      pend_sum_ff  <= pend_sum_in;
      pend_cnt_ff  <= pend_cnt_in;
      pend_bank_ff <= pend_bank_in;
   end

   // Output register load.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = head_valid_ff;
      end
      if (emit) begin
         if (idx_ff == '0) begin
            rsp_data_in = head_sum_ff;
         end else begin
            rsp_data_in               = '0;
            rsp_data_in.kind          = ethhdr_pkg::KIND_PAYLOAD;
            rsp_data_in.last_of_frame = emit_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // Payload RAM: one write port for the filling bank, one read port for the
   // draining bank. The read register feeds the output directly.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pay_mem[mem_waddr] <= b;
      end
      if (mem_re) begin
         rd_data_ff <= pay_mem[mem_raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_data               = rsp_data_ff;
      rsp_data.payload_value = (rsp_data_ff.kind == ethhdr_pkg::KIND_PAYLOAD) ?
                               rd_data_ff : 8'd0;
   end

   // A frame can wait only behind a frame that is being reported.
   `ASSERT_IMPLIES(a_pend_needs_head, clock, reset, pend_valid_ff, head_valid_ff, "waiting frame without head frame")

   // The filling bank never collides with the bank being drained.
   `ASSERT_IMPLIES(a_bank_split, clock, reset, mem_we && head_valid_ff && idx_ff != '0, wbank_ff != head_bank_ff, "payload write into draining bank")

   // The result index never runs past the frame's payload count.
   `ASSERT_IMPLIES(a_idx_range, clock, reset, head_valid_ff, idx_ff <= head_cnt_ff, "result index beyond payload count")

   // A stalled result is held for the next cycle.
   `ASSERT_NEXT(a_out_hold, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff && $stable(rsp_data_ff), "stalled result changed")

endmodule
